>>> rtl/assert_macros.svh
// Assertion macros shared by the line deframer RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rstn, cond, msg)
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

>>> rtl/pcd_pkg.sv
// Package for the parity/checksum line deframer: widths, reset values,
// register indexes and the controller/datapath command and status structs.
package pcd_pkg;

  localparam int BYTE_W         = 8;
  localparam int TOTAL_W        = 16;
  localparam int SUM_W          = 14;
  localparam int CFG_IDX_W      = 2;
  localparam int LINE_BYTES_DEF = 64;

  localparam logic [BYTE_W-1:0]    TERM_RESET = 8'd20;
  localparam logic [BYTE_W-1:0]    MARK_RESET = 8'd64;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK   = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_data;  // data or terminator byte accepted
    logic take_ckh;   // high checksum byte accepted
    logic take_ckl;   // low checksum byte accepted, line end decision
    logic clear;      // line state back to empty
    logic rd_en;      // read the buffer at the slot index
    logic cnt_rd;     // this read feeds the mark counter
    logic idx_inc;    // advance the slot index
    logic idx_zero;   // rewind the slot index
    logic load;       // load one slot into the output register
  } pcd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_term;    // input byte equals the terminator
    logic pf;         // a parity error was seen in this line
    logic len_zero;   // no slot stored
    logic rd_last;    // slot index points at the final stored slot
    logic out_free;   // output register can take a slot this cycle
  } pcd_sts_t;

  function automatic logic even_parity(input logic [BYTE_W-1:0] v);
    return ~(^v);
  endfunction

endpackage

>>> rtl/pcd_in_if.sv
// Input request channel of the line deframer: one raw byte per request.
// Depends on pcd_pkg.
interface pcd_in_if;
  import pcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] raw_byte;

  modport source (output valid, output raw_byte, input ready);
  modport sink (input valid, input raw_byte, output ready);
endinterface

>>> rtl/pcd_out_if.sv
// Result request channel of the line deframer: one line slot per request.
// Depends on pcd_pkg.
interface pcd_out_if;
  import pcd_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic               last;
  logic [TOTAL_W-1:0] bad_byte_total;
  logic [TOTAL_W-1:0] bad_line_total;

  modport source (output valid, output out_byte, output last, output bad_byte_total,
                  output bad_line_total, input ready);
  modport sink (input valid, input out_byte, input last, input bad_byte_total,
                input bad_line_total, output ready);
endinterface

>>> rtl/pcd_ctrl.sv
// Controller of the line deframer: phase tracking and the buffer walks
// at line end. Depends on pcd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pcd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pcd_pkg::pcd_sts_t sts_i,
  output pcd_pkg::pcd_cmd_t cmd_o
);
  import pcd_pkg::*;

  typedef enum logic [6:0] {
    S_DATA   = 7'b0000001,
    S_CKH    = 7'b0000010,
    S_CKL    = 7'b0000100,
    S_COUNT  = 7'b0001000,
    S_CNTEND = 7'b0010000,
    S_EMRD   = 7'b0100000,
    S_EMWR   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_ready_o = state_r inside {S_DATA, S_CKH, S_CKL};
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      S_DATA: begin
        if (in_fire) begin
          cmd_o.take_data = 1'b1;
          if (sts_i.is_term) state_nxt = S_CKH;
        end
      end
      S_CKH: begin
        if (in_fire) begin
          cmd_o.take_ckh = 1'b1;
          state_nxt      = S_CKL;
        end
      end
      S_CKL: begin
        if (in_fire) begin
          cmd_o.take_ckl = 1'b1;
          if (sts_i.len_zero) begin
            cmd_o.clear = 1'b1;
            state_nxt   = S_DATA;
          end else if (sts_i.pf) begin
            state_nxt = S_COUNT;
          end else begin
            state_nxt = S_EMRD;
          end
        end
      end
      S_COUNT: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.cnt_rd  = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.rd_last) state_nxt = S_CNTEND;
      end
      S_CNTEND: begin
        cmd_o.idx_zero = 1'b1;
        state_nxt      = S_EMRD;
      end
      S_EMRD: begin
        cmd_o.rd_en = 1'b1;
        state_nxt   = S_EMWR;
      end
      S_EMWR: begin
        if (sts_i.out_free) begin
          cmd_o.load    = 1'b1;
          cmd_o.idx_inc = 1'b1;
          if (sts_i.rd_last) begin
            cmd_o.clear = 1'b1;
            state_nxt   = S_DATA;
          end else begin
            state_nxt = S_EMRD;
          end
        end
      end
      default: state_nxt = S_DATA;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_DATA;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_NEXT(a_emit_waits, clk, rst_n, (state_r == S_EMWR) && !sts_i.out_free,
               state_r == S_EMWR, "slot dropped while output register busy")
  `ASSERT_IMPLY(a_no_load_when_taking, clk, rst_n, in_ready_o, !cmd_o.load && !cmd_o.rd_en,
                "buffer walk while input is open")
  `ASSERT_NEXT(a_pf_counts, clk, rst_n, in_fire && (state_r == S_CKL) && sts_i.pf &&
               !sts_i.len_zero, state_r == S_COUNT, "parity-failed line skipped counting")
  `ASSERT_NEXT(a_last_returns, clk, rst_n, cmd_o.load && sts_i.rd_last,
               state_r == S_DATA, "line end did not reopen input")
endmodule

>>> rtl/pcd_dp.sv
// Datapath of the line deframer: config registers, line buffer, line sum,
// flags, running totals and the output register. Depends on pcd_pkg and
// assert_macros.svh.
`include "assert_macros.svh"
module pcd_dp #(
  parameter int LINE_BYTES = pcd_pkg::LINE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcd_pkg::BYTE_W-1:0]     cfg_wdata,
  input  logic [pcd_pkg::BYTE_W-1:0]     raw_byte_i,
  input  pcd_pkg::pcd_cmd_t              cmd_i,
  output pcd_pkg::pcd_sts_t              sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pcd_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                           out_last_o,
  output logic [pcd_pkg::TOTAL_W-1:0]    bad_byte_total_o,
  output logic [pcd_pkg::TOTAL_W-1:0]    bad_line_total_o
);
  import pcd_pkg::*;

  localparam int LEN_W  = $clog2(LINE_BYTES + 1);
  localparam int ADDR_W = $clog2(LINE_BYTES);
  localparam logic [LEN_W-1:0]   LEN_FULL = LEN_W'(LINE_BYTES);
  localparam logic [TOTAL_W-1:0] TOT_MAX  = {TOTAL_W{1'b1}};

  logic [BYTE_W-1:0]  term_r, mark_r;
  logic [BYTE_W-1:0]  mem [LINE_BYTES];
  logic [BYTE_W-1:0]  rd_data_r;
  logic [LEN_W-1:0]   len_r, data_len_r;
  logic [SUM_W-1:0]   sum_r;
  logic               pf_r, ovf_r, mark_all_r, cmp_vld_r;
  logic [BYTE_W-1:0]  cks_hi_r;
  logic [ADDR_W-1:0]  idx_r;
  logic [TOTAL_W-1:0] bad_bytes_r, bad_lines_r;
  logic               out_valid_r, out_last_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic [TOTAL_W-1:0] out_bb_r, out_bl_r;

  logic              full, good, store, line_fail;
  logic [BYTE_W-1:0] wr_data, slot_val;

  assign full      = (len_r == LEN_FULL);
  assign good      = even_parity(raw_byte_i);
  assign store     = cmd_i.take_data && !full;
  assign wr_data   = good ? {1'b0, raw_byte_i[BYTE_W-1:1]} : mark_r;
  assign line_fail = !pf_r && (({{(TOTAL_W - SUM_W){1'b0}}, sum_r} != {cks_hi_r, raw_byte_i})
                               || ovf_r);
  assign slot_val  = (mark_all_r && (LEN_W'(idx_r) < data_len_r)) ? mark_r : rd_data_r;

  assign sts_o.is_term  = (raw_byte_i == term_r);
  assign sts_o.pf       = pf_r;
  assign sts_o.len_zero = (len_r == '0);
  assign sts_o.rd_last  = (LEN_W'(idx_r) == (len_r - LEN_W'(1)));
  assign sts_o.out_free = !out_valid_r || out_ready_i;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r <= TERM_RESET;
      mark_r <= MARK_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TERM) term_r <= cfg_wdata;
      if (cfg_index == CFG_MARK) mark_r <= cfg_wdata;
    end
  end

  // Line buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (store) mem[len_r[ADDR_W-1:0]] <= wr_data;
    if (cmd_i.rd_en) rd_data_r <= mem[idx_r];
  end

  // Line state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      data_len_r <= '0;
      sum_r      <= '0;
      pf_r       <= 1'b0;
      ovf_r      <= 1'b0;
      mark_all_r <= 1'b0;
      cks_hi_r   <= '0;
    end else if (cmd_i.clear) begin
      len_r      <= '0;
      data_len_r <= '0;
      sum_r      <= '0;
      pf_r       <= 1'b0;
      ovf_r      <= 1'b0;
      mark_all_r <= 1'b0;
      cks_hi_r   <= '0;
    end else begin
      if (cmd_i.take_data && sts_o.is_term) data_len_r <= len_r;
      if (cmd_i.take_data && full) ovf_r <= 1'b1;
      if (store) begin
        len_r <= len_r + LEN_W'(1);
        sum_r <= sum_r + SUM_W'(raw_byte_i);
        if (!good) pf_r <= 1'b1;
      end
      if (cmd_i.take_ckh) cks_hi_r <= raw_byte_i;
      if (cmd_i.take_ckl) mark_all_r <= line_fail;
    end
  end

  // Slot index and mark counter pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd_i.cnt_rd;
      if (cmd_i.take_ckl || cmd_i.idx_zero) idx_r <= '0;
      else if (cmd_i.idx_inc) idx_r <= idx_r + ADDR_W'(1);
    end
  end

  // Running totals, saturating.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_bytes_r <= '0;
      bad_lines_r <= '0;
    end else begin
      if (cmp_vld_r && (rd_data_r == mark_r) && (bad_bytes_r != TOT_MAX))
        bad_bytes_r <= bad_bytes_r + TOTAL_W'(1);
      if (cmd_i.take_ckl && line_fail && (bad_lines_r != TOT_MAX))
        bad_lines_r <= bad_lines_r + TOTAL_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      out_byte_r <= slot_val;
      out_last_r <= sts_o.rd_last;
      out_bb_r   <= bad_bytes_r;
      out_bl_r   <= bad_lines_r;
    end
  end

  assign out_valid_o      = out_valid_r;
  assign out_byte_o       = out_byte_r;
  assign out_last_o       = out_last_r;
  assign bad_byte_total_o = out_bb_r;
  assign bad_line_total_o = out_bl_r;

  `ASSERT_ALWAYS(a_len_bound, clk, rst_n, len_r <= LEN_FULL, "line length past buffer")
  `ASSERT_IMPLY(a_ovf_full, clk, rst_n, ovf_r, full, "overflow flagged with room left")
  `ASSERT_NEXT(a_last_clears, clk, rst_n, cmd_i.load && sts_o.rd_last,
               (len_r == '0) && !pf_r && out_last_r, "line state kept after final slot")
endmodule

>>> rtl/parity_checksum_line_deframer.sv
// Parity/checksum line deframer, top level: controller plus datapath.
// Depends on pcd_pkg, pcd_in_if, pcd_out_if, pcd_ctrl and pcd_dp.
//
// The block takes raw bytes one per request. Each data byte is checked for
// even parity; a good byte is kept shifted right by one and a bad one is kept
// as the mark character. The terminator byte is stored and summed like data,
// and the two bytes after it form a big-endian checksum that is compared
// against the 14-bit line sum. If the line had no parity error but the
// checksum does not match (or the line overran its buffer of LINE_BYTES
// slots), every slot before the terminator slot comes out as the mark and the
// bad line total rises. If the line had a parity error, the slots equal to the
// mark are counted into the bad byte total first. Each output request carries
// one slot, a last flag on the final slot, and both totals as they stand after
// this line. The input never stalls on data or checksum bytes. At line end
// the input stalls while the buffer, a single memory with a registered read
// port, is walked: a parity-failed line first gets a counting pass over its
// stored slots, then each slot is read from the buffer and then loaded into
// the output register, and the walk waits while the sink stalls. The output
// register lets the last slot wait while the next line's bytes come in.
// Configuration writes take effect on the next cycle; index 0 is the
// terminator, index 1 the mark, other indexes are ignored. The buffer needs
// no clearing after reset.
module parity_checksum_line_deframer #(
  parameter int LINE_BYTES = pcd_pkg::LINE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcd_pkg::BYTE_W-1:0]    cfg_wdata,
  pcd_in_if.sink                        in_ch,
  pcd_out_if.source                     out_ch
);
  import pcd_pkg::*;

  pcd_cmd_t cmd;
  pcd_sts_t sts;

  // The controller owns the handshake on the input side and sequences the
  // line-end walks; the datapath owns all storage and the output register.
  pcd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcd_dp #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .raw_byte_i       (in_ch.raw_byte),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_ch.valid),
    .out_ready_i      (out_ch.ready),
    .out_byte_o       (out_ch.out_byte),
    .out_last_o       (out_ch.last),
    .bad_byte_total_o (out_ch.bad_byte_total),
    .bad_line_total_o (out_ch.bad_line_total)
  );
endmodule
